// ===== design/mi_pkg.sv =====
// Shared types and constants for the 3x3 matrix inverse pipeline.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none
package mi_pkg;
  localparam int MI_DIM       = 3;
  localparam int MI_NUM       = 9;
  localparam int MI_W         = 32;
  localparam int MI_CW        = 64;
  localparam int MI_DETW      = 98;
  localparam int MI_QW        = 32;
  localparam int MI_FRAC_BITS = 16;

  typedef struct packed {
    logic valid;
    logic sing;
  } mi_ctrl_t;

  typedef struct packed {
    logic neg;
    logic ovf;
  } mi_lane_t;
endpackage
`default_nettype wire

// ===== design/mi_cofactor.sv =====
// Two pipeline stages: the eighteen entry products, then the nine cofactors.
// Depends on mi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mi_cofactor import mi_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         ce,
  input  wire logic                         in_valid,
  input  wire logic [MI_NUM-1:0][MI_W-1:0]  a_in,
  output logic                              cof_valid,
  output logic signed [MI_CW-1:0]           cof [MI_NUM],
  output logic signed [MI_W-1:0]            row0 [MI_DIM]
);
  logic signed [MI_W-1:0]  a [MI_NUM];
  logic signed [MI_CW-1:0] pa_r [MI_NUM];
  logic signed [MI_CW-1:0] pb_r [MI_NUM];
  logic signed [MI_CW-1:0] cof_r [MI_NUM];
  logic signed [MI_W-1:0]  row0_a_r [MI_DIM];
  logic signed [MI_W-1:0]  row0_b_r [MI_DIM];
  logic                    v1_r, v2_r;

  for (genvar r = 0; r < MI_DIM; r++) begin : g_r
    for (genvar c = 0; c < MI_DIM; c++) begin : g_c
      localparam int K  = r * MI_DIM + c;
      localparam int R1 = (r + 1) % MI_DIM;
      localparam int R2 = (r + 2) % MI_DIM;
      localparam int C1 = (c + 1) % MI_DIM;
      localparam int C2 = (c + 2) % MI_DIM;
      assign a[K] = $signed(a_in[K]);
      always_ff @(posedge clk) begin
        if (ce) begin
          pa_r[K]  <= a[R1*MI_DIM+C1] * a[R2*MI_DIM+C2];
          pb_r[K]  <= a[R1*MI_DIM+C2] * a[R2*MI_DIM+C1];
          cof_r[K] <= pa_r[K] - pb_r[K];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        row0_a_r[r] <= a[r];
        row0_b_r[r] <= row0_a_r[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  assign cof_valid = v2_r;
  assign cof       = cof_r;
  assign row0      = row0_b_r;
endmodule
`default_nettype wire

// ===== design/mi_det.sv =====
// Four stages: determinant partial products, their sum, sign and magnitude,
// then the rounded numerators and the high quotient overflow check. Uses mi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mi_det import mi_pkg::*; #(
  parameter int FRAC_BITS = MI_FRAC_BITS,
  parameter int RW        = 99
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    ce,
  input  wire logic                    cof_valid,
  input  wire logic signed [MI_CW-1:0] cof [MI_NUM],
  input  wire logic signed [MI_W-1:0]  row0 [MI_DIM],
  output mi_ctrl_t                     ctrl,
  output logic [RW-1:0]                den,
  output logic [RW-1:0]                rem [MI_NUM],
  output logic [MI_QW-1:0]             numlo [MI_NUM],
  output mi_lane_t                     flags [MI_NUM]
);
  localparam int SH = 2 * FRAC_BITS + 1;

  logic signed [MI_CW:0]     pl_r [MI_DIM];
  logic signed [MI_CW-1:0]   ph_r [MI_DIM];
  logic signed [MI_CW-1:0]   cof3_r [MI_NUM];
  logic signed [MI_CW-1:0]   cof4_r [MI_NUM];
  logic signed [MI_DETW-1:0] term [MI_DIM];
  logic signed [MI_DETW-1:0] det_r;
  logic [MI_DETW-1:0]        dmag_r;
  logic                      dz_r;
  logic [MI_CW-1:0]          cm_r [MI_NUM];
  logic                      neg5_r [MI_NUM];
  logic [RW-1:0]             num [MI_NUM];
  logic [RW-1:0]             hi [MI_NUM];
  logic [RW-1:0]             den_w;
  logic [RW-1:0]             den_r;
  logic [RW-1:0]             rem_r [MI_NUM];
  logic [MI_QW-1:0]          numlo_r [MI_NUM];
  mi_lane_t                  flags_r [MI_NUM];
  logic                      sing_r;
  logic                      v3_r, v4_r, v5_r, v6_r;

  assign den_w = RW'(dmag_r) << 1;

  for (genvar c = 0; c < MI_DIM; c++) begin : g_det
    assign term[c] = (MI_DETW'(ph_r[c]) <<< MI_W) + MI_DETW'(pl_r[c]);
    always_ff @(posedge clk) begin
      if (ce) begin
        pl_r[c] <= row0[c] * $signed({1'b0, cof[c][MI_W-1:0]});
        ph_r[c] <= row0[c] * $signed(cof[c][MI_CW-1:MI_W]);
      end
    end
  end

  for (genvar r = 0; r < MI_DIM; r++) begin : g_r
    for (genvar c = 0; c < MI_DIM; c++) begin : g_c
      localparam int K = r * MI_DIM + c;
      localparam int T = c * MI_DIM + r;
      assign num[K] = (RW'(cm_r[K]) << SH) + RW'(dmag_r);
      assign hi[K]  = num[K] >> MI_QW;
      always_ff @(posedge clk) begin
        if (ce) begin
          cof3_r[K]     <= cof[K];
          cof4_r[K]     <= cof3_r[K];
          cm_r[K]       <= cof4_r[T][MI_CW-1] ? MI_CW'(-cof4_r[T]) : MI_CW'(cof4_r[T]);
          neg5_r[K]     <= (cof4_r[T][MI_CW-1] != det_r[MI_DETW-1]) && (cof4_r[T] != '0);
          rem_r[K]      <= (hi[K] >= den_w) ? '0 : hi[K];
          numlo_r[K]    <= num[K][MI_QW-1:0];
          flags_r[K].neg <= neg5_r[K];
          flags_r[K].ovf <= hi[K] >= den_w;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      det_r  <= term[0] + term[1] + term[2];
      dmag_r <= det_r[MI_DETW-1] ? MI_DETW'(-det_r) : MI_DETW'(det_r);
      dz_r   <= det_r == '0;
      den_r  <= den_w;
      sing_r <= dz_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (ce) begin
      v3_r <= cof_valid;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  assign ctrl.valid = v6_r;
  assign ctrl.sing  = sing_r;
  assign den        = den_r;
  assign rem        = rem_r;
  assign numlo      = numlo_r;
  assign flags      = flags_r;
endmodule
`default_nettype wire

// ===== design/mi_div_step.sv =====
// One restoring division stage: one quotient bit for each of the nine lanes.
// Uses mi_pkg; chained by the top level to form the pipelined divider.
`timescale 1ns / 1ps
`default_nettype none
module mi_div_step import mi_pkg::*; #(
  parameter int RW = 99
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             ce,
  input  wire mi_ctrl_t         ctrl_in,
  input  wire logic [RW-1:0]    den_in,
  input  wire logic [RW-1:0]    rem_in [MI_NUM],
  input  wire logic [MI_QW-1:0] numlo_in [MI_NUM],
  input  wire logic [MI_QW-1:0] q_in [MI_NUM],
  input  wire mi_lane_t         flags_in [MI_NUM],
  output mi_ctrl_t              ctrl_out,
  output logic [RW-1:0]         den_out,
  output logic [RW-1:0]         rem_out [MI_NUM],
  output logic [MI_QW-1:0]      numlo_out [MI_NUM],
  output logic [MI_QW-1:0]      q_out [MI_NUM],
  output mi_lane_t              flags_out [MI_NUM]
);
  logic [RW-1:0]    t [MI_NUM];
  logic             ge [MI_NUM];
  logic [RW-1:0]    rem_r [MI_NUM];
  logic [MI_QW-1:0] numlo_r [MI_NUM];
  logic [MI_QW-1:0] q_r [MI_NUM];
  mi_lane_t         flags_r [MI_NUM];
  logic [RW-1:0]    den_r;
  logic             sing_r;
  logic             valid_r;

  for (genvar k = 0; k < MI_NUM; k++) begin : g_lane
    assign t[k]  = {rem_in[k][RW-2:0], numlo_in[k][MI_QW-1]};
    assign ge[k] = t[k] >= den_in;
    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[k]   <= ge[k] ? t[k] - den_in : t[k];
        numlo_r[k] <= numlo_in[k] << 1;
        q_r[k]     <= {q_in[k][MI_QW-2:0], ge[k]};
        flags_r[k] <= flags_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      den_r  <= den_in;
      sing_r <= ctrl_in.sing;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ce) begin
      valid_r <= ctrl_in.valid;
    end
  end

  assign ctrl_out.valid = valid_r;
  assign ctrl_out.sing  = sing_r;
  assign den_out        = den_r;
  assign rem_out        = rem_r;
  assign numlo_out      = numlo_r;
  assign q_out          = q_r;
  assign flags_out      = flags_r;
endmodule
`default_nettype wire

// ===== design/matrix3_inverse.sv =====
// An accepted input word passes the cofactor, determinant and divider stages, then the output register.
// Throughput: one matrix per cycle while the output is not stalled; the 32-stage quotient divider sets the depth.
// The whole pipeline advances together and holds while a result waits.
// Reset (synchronous, active low) clears all valid bits; data is not reset.
`timescale 1ns / 1ps
`default_nettype none
module matrix3_inverse import mi_pkg::*; #(
  parameter int FRAC_BITS = MI_FRAC_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // a00, a01, a02, a10, a11, a12, a20, a21, a22, 32 bits each.
  input  wire logic [MI_NUM*MI_W-1:0]    in_tdata,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // b00, b01, b02, b10, b11, b12, b20, b21, b22, 32 bits each.
  output logic [MI_NUM*MI_W-1:0]         out_tdata,
  // singular, overflow.
  output logic [1:0]                     out_tuser
);
  localparam int NW = MI_CW + 2 * FRAC_BITS + 2;
  localparam int RW = ((NW > MI_DETW) ? NW : MI_DETW) + 1;

  logic                          ce;
  logic [MI_NUM-1:0][MI_W-1:0]   a_in;
  logic                          cof_valid;
  logic signed [MI_CW-1:0]       cof [MI_NUM];
  logic signed [MI_W-1:0]        row0 [MI_DIM];

  mi_ctrl_t                      s_ctrl [MI_QW+1];
  logic [RW-1:0]                 s_den [MI_QW+1];
  logic [RW-1:0]                 s_rem [MI_QW+1][MI_NUM];
  logic [MI_QW-1:0]              s_numlo [MI_QW+1][MI_NUM];
  logic [MI_QW-1:0]              s_q [MI_QW+1][MI_NUM];
  mi_lane_t                      s_flags [MI_QW+1][MI_NUM];

  logic [MI_QW:0]                lim [MI_NUM];
  logic                          sat [MI_NUM];
  logic [MI_W-1:0]               mag [MI_NUM];
  logic [MI_NUM*MI_W-1:0]        data_nxt;
  logic [MI_NUM-1:0]             sat_vec;
  logic [MI_NUM*MI_W-1:0]        data_r;
  logic [1:0]                    user_r;
  logic                          valid_r;

  assign ce        = !valid_r || out_tready;
  assign in_tready = ce;
  assign a_in      = in_tdata;

  mi_cofactor u_cof (
    .clk(clk), .rst_n(rst_n), .ce(ce), .in_valid(in_tvalid),
    .a_in(a_in), .cof_valid(cof_valid), .cof(cof), .row0(row0)
  );

  mi_det #(.FRAC_BITS(FRAC_BITS), .RW(RW)) u_det (
    .clk(clk), .rst_n(rst_n), .ce(ce), .cof_valid(cof_valid), .cof(cof),
    .row0(row0), .ctrl(s_ctrl[0]), .den(s_den[0]), .rem(s_rem[0]),
    .numlo(s_numlo[0]), .flags(s_flags[0])
  );

  for (genvar k = 0; k < MI_NUM; k++) begin : g_q0
    assign s_q[0][k] = '0;
  end

  for (genvar i = 0; i < MI_QW; i++) begin : g_div
    mi_div_step #(.RW(RW)) u_step (
      .clk(clk), .rst_n(rst_n), .ce(ce),
      .ctrl_in(s_ctrl[i]), .den_in(s_den[i]), .rem_in(s_rem[i]),
      .numlo_in(s_numlo[i]), .q_in(s_q[i]), .flags_in(s_flags[i]),
      .ctrl_out(s_ctrl[i+1]), .den_out(s_den[i+1]), .rem_out(s_rem[i+1]),
      .numlo_out(s_numlo[i+1]), .q_out(s_q[i+1]), .flags_out(s_flags[i+1])
    );
  end

  for (genvar k = 0; k < MI_NUM; k++) begin : g_out
    assign lim[k] = s_flags[MI_QW][k].neg ? (MI_QW+1)'(1) << (MI_W - 1)
                                          : ((MI_QW+1)'(1) << (MI_W - 1)) - 1'b1;
    assign sat[k] = s_flags[MI_QW][k].ovf || ({1'b0, s_q[MI_QW][k]} > lim[k]);
    assign mag[k] = sat[k] ? lim[k][MI_W-1:0] : s_q[MI_QW][k];
    assign sat_vec[k] = sat[k];
    assign data_nxt[k*MI_W +: MI_W] = s_ctrl[MI_QW].sing ? '0 :
                                      (s_flags[MI_QW][k].neg ? -mag[k] : mag[k]);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      data_r <= data_nxt;
      user_r <= {!s_ctrl[MI_QW].sing && (|sat_vec), s_ctrl[MI_QW].sing};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ce) begin
      valid_r <= s_ctrl[MI_QW].valid;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

  a_singular_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tuser[1] && out_tdata == '0)
    else $error("singular result carries data or overflow");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");
endmodule
`default_nettype wire
